// ===== rtl/core/cslex_pkg.sv =====
package cslex_pkg;

    localparam int MAX_NAME_LEN  = 63;
    localparam int POSITION_BITS = 32;
    localparam int NLEN_BITS     = $clog2(MAX_NAME_LEN + 1);

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int LINE_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int START_W  = 32;
    localparam int LENGTH_W = 6;
    localparam int FIELDS_W = LINE_W + VALUE_W + START_W + LENGTH_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 4'd0,
        KIND_LPAR   = 4'd1,
        KIND_RPAR   = 4'd2,
        KIND_LBRACE = 4'd3,
        KIND_RBRACE = 4'd4,
        KIND_SEMI   = 4'd5,
        KIND_INT    = 4'd6,
        KIND_CHAR   = 4'd7,
        KIND_VOID   = 4'd8,
        KIND_RETURN = 4'd9,
        KIND_NAME   = 4'd10,
        KIND_NUMBER = 4'd11
    } t_kind;

    // Keyword candidate codes; the kind of a keyword is KIND_SEMI plus its code.
    localparam logic [2:0] KW_NONE   = 3'd0;
    localparam logic [2:0] KW_INT    = 3'd1;
    localparam logic [2:0] KW_CHAR   = 3'd2;
    localparam logic [2:0] KW_VOID   = 3'd3;
    localparam logic [2:0] KW_RETURN = 3'd4;

    typedef struct packed {
        t_kind                kind;
        logic [LINE_W-1:0]    line;
        logic [VALUE_W-1:0]   value;
        logic [START_W-1:0]   start;
        logic [LENGTH_W-1:0]  length;
        logic                 last;
    } t_token;

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            KW_INT:    n = 3'd3;
            KW_CHAR:   n = 3'd4;
            KW_VOID:   n = 3'd4;
            KW_RETURN: n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Character at position i of keyword k; only meaningful for i below its length.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [47:0] txt;
        logic [2:0]  sel;
        unique case (k)
            KW_INT:    txt = 48'("int");
            KW_CHAR:   txt = 48'("char");
            KW_VOID:   txt = 48'("void");
            KW_RETURN: txt = 48'("return");
            default:   txt = '0;
        endcase
        sel = kw_len(k) - 3'd1 - i;
        return txt[8*sel +: 8];
    endfunction

    function automatic logic [2:0] kw_first(input logic [7:0] b);
        logic [2:0] k;
        unique case (b)
            8'h69:   k = KW_INT;
            8'h63:   k = KW_CHAR;
            8'h76:   k = KW_VOID;
            8'h72:   k = KW_RETURN;
            default: k = KW_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/c_subset_lexer_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata[7:0] source_byte
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata line/value/start/length,
//                                               tuser kind, tlast last
//
// One source byte is taken per cycle, unless s_axis is stalled, into an input
// register; from there it is lexed and its tokens are written into a two-entry
// output queue. A byte that yields two tokens waits in the input register until
// the queue has two free slots.
// Synchronous active-low reset empties both stages and returns the scanner
// to the between-tokens state with the line count at one.
// Back pressure on m_axis fills the queue and then stalls s_axis.
module c_subset_lexer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [7:0] source_byte
    input  logic [cslex_pkg::BYTE_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [31:0] token_line, [63:32] number_value, [95:64] name_start,
    // [101:96] name_length, [103:102] zero
    output logic [cslex_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // [3:0] token_kind
    output logic [cslex_pkg::KIND_W-1:0]  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);
    import cslex_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_NUMBER = 2'd2
    } t_mode;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Scanner state.
    t_mode                  r_mode, n_mode;
    logic [2:0]             r_kw, n_kw;
    logic [NLEN_BITS-1:0]   r_len, n_len;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [VALUE_W-1:0]     r_acc, n_acc;
    logic [LINE_W-1:0]      r_line, n_line;
    logic [LINE_W-1:0]      r_latch, n_latch;

    // Output queue.
    t_token     r_q [2];
    t_token     n_q [2];
    logic [1:0] r_cnt, n_cnt;

    logic       pop, commit;
    logic [1:0] free_slots;
    logic [1:0] ntok;
    t_token     tok_a, tok_b;

    logic [7:0] b;
    logic       is_letter, is_digit, is_blank, is_punct, ends_word;
    t_kind      punct_kind;
    logic [63:0] start_wide;

    assign b         = r_in_byte;
    assign is_letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    assign is_digit  = b >= 8'h30 && b <= 8'h39;
    assign is_blank  = b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    assign is_punct  = b == 8'h28 || b == 8'h29 || b == 8'h7b || b == 8'h7d || b == 8'h3b;
    assign start_wide = 64'(r_start);

    always_comb begin
        unique case (b)
            8'h28:   punct_kind = KIND_LPAR;
            8'h29:   punct_kind = KIND_RPAR;
            8'h7b:   punct_kind = KIND_LBRACE;
            8'h7d:   punct_kind = KIND_RBRACE;
            default: punct_kind = KIND_SEMI;
        endcase
    end

    assign pop        = o_m_axis_tvalid && i_m_axis_tready;
    assign free_slots = 2'd2 - r_cnt + {1'b0, pop};
    assign commit     = r_in_valid && (free_slots >= ntok);
    assign o_s_axis_tready = !r_in_valid || commit;

    always_comb begin
        t_token     first_tok, second_tok;
        logic       has_first, has_second;
        logic [2:0] klen;

        n_mode  = r_mode;
        n_kw    = r_kw;
        n_len   = r_len;
        n_start = r_start;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_line  = r_line;
        n_latch = r_latch;

        first_tok  = '{kind: KIND_END, line: r_latch, value: '0, start: '0,
                       length: '0, last: 1'b1};
        second_tok = first_tok;
        has_first  = 1'b0;
        has_second = 1'b0;
        ends_word  = 1'b0;
        klen       = kw_len(r_kw);

        // A name or number ends at the first byte that cannot extend it.
        unique case (r_mode)
            MODE_NAME: begin
                if (is_letter || is_digit) begin
                    if (r_kw == KW_NONE || r_kw > KW_RETURN ||
                        r_len >= NLEN_BITS'(klen) || kw_char(r_kw, r_len[2:0]) != b)
                        n_kw = KW_NONE;
                    if (r_len < NLEN_BITS'(MAX_NAME_LEN))
                        n_len = r_len + NLEN_BITS'(1);
                end else begin
                    ends_word = 1'b1;
                    has_first = 1'b1;
                    if (r_kw >= KW_INT && r_kw <= KW_RETURN && r_len == NLEN_BITS'(klen)) begin
                        first_tok.kind = t_kind'(KIND_W'(KIND_SEMI) + KIND_W'(r_kw));
                    end else begin
                        first_tok.kind   = KIND_NAME;
                        first_tok.start  = start_wide[START_W-1:0];
                        first_tok.length = LENGTH_W'(r_len);
                    end
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + VALUE_W'(b - 8'h30);
                end else begin
                    ends_word       = 1'b1;
                    has_first       = 1'b1;
                    first_tok.kind  = KIND_NUMBER;
                    first_tok.value = r_acc;
                end
            end
            default: ends_word = 1'b1;
        endcase

        if (ends_word) begin
            n_mode = MODE_IDLE;
            second_tok.line = has_first ? r_line : r_latch;
            priority if (is_blank) begin
                if (b == 8'h0a)
                    n_line = r_line + LINE_W'(1);
            end else if (b == 8'h00) begin
                has_second = 1'b1;
            end else if (is_punct) begin
                has_second      = 1'b1;
                second_tok.kind = punct_kind;
            end else if (is_letter) begin
                n_start = r_pos;
                n_len   = NLEN_BITS'(1);
                n_kw    = kw_first(b);
                n_mode  = MODE_NAME;
            end else if (is_digit) begin
                n_acc  = VALUE_W'(b - 8'h30);
                n_mode = MODE_NUMBER;
            end else begin
                has_second = 1'b1;
            end
        end

        // The end-of-text byte is the only one that leaves the offset alone.
        if (!(ends_word && b == 8'h00))
            n_pos = r_pos + POSITION_BITS'(1);

        if (has_first || has_second)
            n_latch = r_line;

        first_tok.last = !has_second;
        ntok = {1'b0, has_first} + {1'b0, has_second};
        if (has_first) begin
            tok_a = first_tok;
            tok_b = second_tok;
        end else begin
            tok_a = second_tok;
            tok_b = second_tok;
        end
    end

    always_comb begin
        logic [1:0] base;
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        base   = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            base   = r_cnt - 2'd1;
        end
        n_cnt = base;
        if (commit && ntok != 2'd0) begin
            n_q[base[0]] = tok_a;
            if (ntok == 2'd2)
                n_q[1] = tok_b;
            n_cnt = base + ntok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_kw       <= KW_NONE;
            r_len      <= '0;
            r_start    <= '0;
            r_pos      <= '0;
            r_acc      <= '0;
            r_line     <= LINE_W'(1);
            r_latch    <= LINE_W'(1);
            r_cnt      <= '0;
        end else begin
            if (o_s_axis_tready)
                r_in_valid <= i_s_axis_tvalid;
            if (commit) begin
                r_mode  <= n_mode;
                r_kw    <= n_kw;
                r_len   <= n_len;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_acc   <= n_acc;
                r_line  <= n_line;
                r_latch <= n_latch;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid)
            r_in_byte <= i_s_axis_tdata;
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_m_axis_tvalid = r_cnt != 2'd0;
    assign o_m_axis_tuser  = r_q[0].kind;
    assign o_m_axis_tlast  = r_q[0].last;
    assign o_m_axis_tdata  = TDATA_W'({r_q[0].length, r_q[0].start,
                                       r_q[0].value, r_q[0].line});

endmodule

// ===== rtl/core/cslex_checker.sv =====
module cslex_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [cslex_pkg::BYTE_W-1:0]  i_s_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [cslex_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [cslex_pkg::KIND_W-1:0]  o_m_axis_tuser,
    input logic                          o_m_axis_tlast
);
    import cslex_pkg::*;

    localparam int VAL_LO = LINE_W;

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("token beat offered right after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= KIND_W'(KIND_NUMBER))
        else $error("token kind out of range");

    // Only name tokens carry a length and start offset.
    a_name_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_W'(KIND_NAME)) |->
        o_m_axis_tdata[TDATA_W-1:VAL_LO+VALUE_W] == '0)
        else $error("non-name token carries name fields");

    a_number_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_W'(KIND_NUMBER)) |->
        o_m_axis_tdata[VAL_LO+VALUE_W-1:VAL_LO] == '0)
        else $error("non-number token carries a value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
         $stable(o_m_axis_tlast)))
        else $error("stalled token beat changed");

endmodule

bind c_subset_lexer_core cslex_checker u_cslex_checker (.*);
